// ===== src/cdtt_pkg.sv =====
// Shared types and constants for the countdown timer table.
`timescale 1ns / 1ps
`default_nettype none
package cdtt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int OP_W        = 2;
    localparam int ID_W        = 16;
    localparam int CNT_W       = 16;

    localparam logic RESULT_ACK  = 1'b0;
    localparam logic RESULT_TICK = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // What a cell does when the token reaches it
    typedef enum logic [2:0] {
        CMD_ARM,
        CMD_INSERT,
        CMD_STOP,
        CMD_TICK,
        CMD_CLEAR
    } t_cmd_mode;

    typedef struct packed {
        t_cmd_mode        mode;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    // Passed from cell to cell: token position and "already matched/inserted"
    typedef struct packed {
        logic tok;
        logic hit;
    } t_link;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  key;
        logic [CNT_W-1:0] left;
        logic             last;
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT
    } t_state;

endpackage
`default_nettype wire

// ===== src/cdtt_ifs.sv =====
// Valid/ready channel interfaces for the timer table command and result streams.
`timescale 1ns / 1ps
`default_nettype none
interface cdtt_in_if;
    import cdtt_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [ID_W-1:0]  timer_id;
    logic [CNT_W-1:0] start_count;

    modport source (output valid, output operation, output timer_id, output start_count,
                    input ready);
    modport sink   (input valid, input operation, input timer_id, input start_count,
                    output ready);
endinterface

interface cdtt_out_if;
    import cdtt_pkg::*;
    logic             valid;
    logic             ready;
    logic             result_kind;
    logic             table_full;
    logic [ID_W-1:0]  event_id;
    logic [CNT_W-1:0] time_left;
    logic             last;

    modport source (output valid, output result_kind, output table_full, output event_id,
                    output time_left, output last, input ready);
    modport sink   (input valid, input result_kind, input table_full, input event_id,
                    input time_left, input last, output ready);
endinterface
`default_nettype wire

// ===== src/cdtt_cell.sv =====
// One timer slot: holds its entry and acts when the token passes through it.
`timescale 1ns / 1ps
`default_nettype none
module cdtt_cell
    import cdtt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire logic   i_notify,
    input  t_cmd        i_cmd,
    input  t_link       i_link,
    output t_link       o_link,
    input  wire logic   i_later_live,
    output logic        o_live_up,
    output t_event      o_ev
);

    logic             r_used, n_used;
    logic             r_en, n_en;
    logic [ID_W-1:0]  r_key, n_key;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_link            r_link, n_link;

    logic             w_match;
    logic             w_live;
    logic             w_act;

    assign w_match   = r_used && (r_key == i_cmd.id);
    assign w_live    = r_used && r_en;
    assign w_act     = i_adv && i_link.tok;
    assign o_live_up = w_live || i_later_live;
    assign o_link    = r_link;

    always_comb begin
        n_used = r_used;
        n_en   = r_en;
        n_key  = r_key;
        n_cnt  = r_cnt;
        n_link = i_link;
        o_ev   = '0;
        if (w_act) begin
            case (i_cmd.mode)
                CMD_ARM: begin
                    if (w_match) begin
                        n_cnt      = i_cmd.cnt;
                        n_en       = 1'b1;
                        n_link.hit = 1'b1;
                    end
                end
                CMD_INSERT: begin
                    // first free slot takes it, later ones see the hit
                    if (!r_used && !i_link.hit) begin
                        n_used     = 1'b1;
                        n_key      = i_cmd.id;
                        n_cnt      = i_cmd.cnt;
                        n_en       = 1'b1;
                        n_link.hit = 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (i_cmd.id == '0 || w_match) begin
                        n_en = 1'b0;
                    end
                end
                CMD_TICK: begin
                    if (w_live) begin
                        if (r_cnt == '0) begin
                            n_en = 1'b0;
                        end else begin
                            n_cnt = r_cnt - CNT_W'(1);
                        end
                        o_ev.valid = i_notify;
                        o_ev.key   = r_key;
                        o_ev.left  = n_cnt;
                        o_ev.last  = !i_later_live;
                    end
                end
                CMD_CLEAR: begin
                    n_used = 1'b0;
                    n_en   = 1'b0;
                end
                default: begin
                    n_link = i_link;
                end
            endcase
        end
        if (!i_adv) begin
            n_link = r_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_en   <= 1'b0;
            r_link <= '0;
        end else begin
            r_used <= n_used;
            r_en   <= n_en;
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_cnt <= n_cnt;
    end

endmodule
`default_nettype wire

// ===== src/countdown_timer_table_core.sv =====
// Countdown timer table: top level with command control, cell chain and result register.
// A command runs as one token pass down a chain of TIMER_SLOTS cells, one cell per
// cycle while the result register is not stalled; stop, clear, tick and a start that
// finds its id need one pass, and a start that must insert a new id runs a second pass
// for the first free slot. Each tick event is emitted by its cell as the token passes,
// in slot order; a stalled result register freezes the whole chain. One command is in
// flight at a time: ready is high only between commands and returns the cycle after a
// pass ends. Results leave through a single output register.
`timescale 1ns / 1ps
`default_nettype none
module countdown_timer_table_core
    import cdtt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_wdata,
    cdtt_in_if.sink     i_cmd,
    cdtt_out_if.source  o_evt
);

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    t_link            r_head, n_head;
    logic             r_notify;
    logic             r_out_v;
    logic             r_out_kind;
    logic             r_out_full;
    logic [ID_W-1:0]  r_out_id;
    logic [CNT_W-1:0] r_out_left;
    logic             r_out_last;

    t_link            w_link [TIMER_SLOTS+1];
    logic             w_live [TIMER_SLOTS+1];
    t_event           w_ev   [TIMER_SLOTS];
    t_event           w_ev_any;
    t_link            w_tail;
    logic             w_adv;
    logic             w_accept;
    logic             w_ack;
    logic             w_ack_full;
    logic             w_launch_ins;

    assign w_adv    = !r_out_v || o_evt.ready;
    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign w_tail   = w_link[TIMER_SLOTS];
    assign w_link[0] = r_head;
    assign w_live[TIMER_SLOTS] = 1'b0;

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        cdtt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (w_adv),
            .i_notify     (r_notify),
            .i_cmd        (r_cmd),
            .i_link       (w_link[g]),
            .o_link       (w_link[g+1]),
            .i_later_live (w_live[g+1]),
            .o_live_up    (w_live[g]),
            .o_ev         (w_ev[g])
        );
    end

    // only the token cell drives a nonzero event
    always_comb begin
        w_ev_any = '0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            w_ev_any = t_event'(w_ev_any | w_ev[i]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tail.tok && w_adv) begin
                    if (r_cmd.mode == CMD_ARM && !w_tail.hit) begin
                        n_state = ST_INSERT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_INSERT: begin
                if (w_tail.tok && w_adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_cmd.ready  = 1'b0;
        w_ack        = 1'b0;
        w_ack_full   = 1'b0;
        w_launch_ins = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
            end
            ST_SCAN: begin
                if (w_tail.tok && r_cmd.mode == CMD_ARM) begin
                    w_ack        = w_tail.hit;
                    w_launch_ins = !w_tail.hit;
                end
            end
            ST_INSERT: begin
                if (w_tail.tok) begin
                    w_ack      = 1'b1;
                    w_ack_full = !w_tail.hit;
                end
            end
            default: begin
                i_cmd.ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_cmd  = r_cmd;
        n_head = r_head;
        if (w_accept) begin
            n_cmd.id  = i_cmd.timer_id;
            n_cmd.cnt = i_cmd.start_count;
            case (t_op'(i_cmd.operation))
                OP_START: n_cmd.mode = CMD_ARM;
                OP_STOP:  n_cmd.mode = CMD_STOP;
                OP_TICK:  n_cmd.mode = CMD_TICK;
                OP_CLEAR: n_cmd.mode = CMD_CLEAR;
                default:  n_cmd.mode = CMD_CLEAR;
            endcase
            n_head = '{tok: 1'b1, hit: 1'b0};
        end else if (w_adv) begin
            n_head = '0;
            if (w_launch_ins) begin
                n_cmd.mode = CMD_INSERT;
                n_head     = '{tok: 1'b1, hit: 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_notify <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            if (i_cfg_we) begin
                r_notify <= i_cfg_wdata;
            end
            if (w_adv) begin
                r_out_v <= w_ev_any.valid || w_ack;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (w_adv) begin
            if (w_ev_any.valid) begin
                r_out_kind <= RESULT_TICK;
                r_out_full <= 1'b0;
                r_out_id   <= w_ev_any.key;
                r_out_left <= w_ev_any.left;
                r_out_last <= w_ev_any.last;
            end else begin
                r_out_kind <= RESULT_ACK;
                r_out_full <= w_ack_full;
                r_out_id   <= r_cmd.id;
                r_out_left <= w_ack_full ? '0 : r_cmd.cnt;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_evt.valid       = r_out_v;
    assign o_evt.result_kind = r_out_kind;
    assign o_evt.table_full  = r_out_full;
    assign o_evt.event_id    = r_out_id;
    assign o_evt.time_left   = r_out_left;
    assign o_evt.last        = r_out_last;

endmodule
`default_nettype wire

// ===== src/cdtt_checker.sv =====
// Port-level checks for the countdown timer table and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cdtt_checker
    import cdtt_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic             i_out_kind,
    input wire logic             i_out_full,
    input wire logic [ID_W-1:0]  i_out_id,
    input wire logic [CNT_W-1:0] i_out_left,
    input wire logic             i_out_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_id) && $stable(i_out_left) && $stable(i_out_kind))
        else $error("result changed while stalled");

    // an acknowledge is always the only result of its start
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == RESULT_ACK |-> i_out_last)
        else $error("acknowledge without last");

    // a dropped start reports an acknowledge with zero count
    a_full_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_full |-> i_out_kind == RESULT_ACK && i_out_left == '0)
        else $error("table_full on a bad result");

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after a transfer");

endmodule

bind countdown_timer_table_core cdtt_checker u_cdtt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_out_kind  (o_evt.result_kind),
    .i_out_full  (o_evt.table_full),
    .i_out_id    (o_evt.event_id),
    .i_out_left  (o_evt.time_left),
    .i_out_last  (o_evt.last)
);
`default_nettype wire
